/* sv/channel_dwell_share_tracker_assert.svh */
// Assertion macros shared by the modules of the channel dwell share tracker.
// Depends on nothing; the using module must have clk_i and rst_ni.
`ifndef CHANNEL_DWELL_SHARE_TRACKER_ASSERT_SVH
`define CHANNEL_DWELL_SHARE_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdst assertion failed");

// Next-cycle implication, checked outside reset.
`define CDST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdst assertion failed");

`endif

/* sv/cdst_pkg.sv */
// Types, constants and the fallback share table of the channel dwell share tracker.
// Depends on nothing.
package cdst_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned DWELL_W  = 32;
  localparam int unsigned WINDOW_W = 33;
  localparam int unsigned SHARE_W  = 10;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned PROD_W   = 42;   // dwell (32 bits) times 1000 (10 bits)
  localparam int unsigned DIV_W    = PROD_W;
  localparam int unsigned CNT_W    = $clog2(DIV_W + 1);

  localparam logic [WINDOW_W-1:0] DECAY_LIMIT = WINDOW_W'(10_000_000);
  localparam logic [SHARE_W-1:0]  PERMIL      = SHARE_W'(1000);

  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [CHAN_W-1:0]   channel;
    logic [DWELL_W-1:0]  duration_us;
  } in_item_t;

  typedef struct packed {
    logic [SHARE_W-1:0] share_permil;
    logic [CHAN_W-1:0]  queried_channel;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic rd_walk;    // read address from the decay walk index
    logic acc_wr;     // add duration to channel and window
    logic win_decay;  // scale the window by 7/8
    logic walk_clr;   // restart the decay walk
    logic dec_wr;     // write back a decayed channel, advance walk
    logic mul_ld;     // load dwell*1000 into the divider
    logic div_step;   // one restoring division step
    logic out_fire;   // register the result and strobe it
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic in_range;
    logic fallback;
    logic over_limit;
    logic walk_last;
    logic div_last;
  } dp_status_t;

  // floor(1000 / n), with n = 0 meaning the default plan of 14 channels.
  function automatic logic [SHARE_W-1:0] fallback_share(input logic [CFG_W-1:0] n);
    logic [SHARE_W-1:0] r;
    case (n)
      4'd0:    r = 10'd71;
      4'd1:    r = 10'd1000;
      4'd2:    r = 10'd500;
      4'd3:    r = 10'd333;
      4'd4:    r = 10'd250;
      4'd5:    r = 10'd200;
      4'd6:    r = 10'd166;
      4'd7:    r = 10'd142;
      4'd8:    r = 10'd125;
      4'd9:    r = 10'd111;
      4'd10:   r = 10'd100;
      4'd11:   r = 10'd90;
      4'd12:   r = 10'd83;
      4'd13:   r = 10'd76;
      4'd14:   r = 10'd71;
      default: r = 10'd66;
    endcase
    return r;
  endfunction

endpackage

/* sv/channel_dwell_share_tracker.sv */
// Top level of the channel dwell share tracker: controller plus datapath.
// Depends on cdst_pkg, cdst_ctrl and cdst_dp (which holds cdst_ram).
//
//   Channel   Signals                      Direction  Transfer
//   item      start, busy, item_i          in         start high while busy low
//   result    res_strobe_o, result_o       out        one cycle, strobe high
//   config    cfg_we_i, cfg_wdata_i        in         every cycle with cfg_we_i high
//
// A query raises the result strobe after its transfer: the dwell RAM is read, dwell
// times 1000 is formed, 42 steps of the restoring divider run and the result is
// registered; a fallback share goes from the read straight to the result register.
// An account item keeps busy high through the read, the accumulate write (skipped
// when the channel is out of range) and the window check, and further while the
// decay walks the dwell RAM when the window passes ten seconds, one read and one
// write-back per channel. Reset is asynchronous and clears the window, the
// configuration and the per-channel valid bits, so every dwell counter reads as
// zero until first written. Results are never held back.
module channel_dwell_share_tracker #(
  parameter int unsigned CHANNEL_MAX = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  cdst_pkg::in_item_t          item_i,
  input  logic                        cfg_we_i,
  input  logic [cdst_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                        res_strobe_o,
  output cdst_pkg::result_t           result_o
);

  // The controller sequences each item; the datapath reports the item kind,
  // the range check, the window limit and the progress of the walk and divider.
  cdst_pkg::dp_cmd_t    dp_cmd;
  cdst_pkg::dp_status_t dp_status;

  cdst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  // The datapath owns all storage, including the plan channel count, which is to be written by the user
  // only while no item is in progress; the block itself does not enforce this.
  cdst_dp #(
    .CHANNEL_MAX (CHANNEL_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .strobe_o    (res_strobe_o),
    .result_o    (result_o)
  );

endmodule

/* sv/cdst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cdst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cdst_ctrl.sv */
// Controller state machine of the channel dwell share tracker.
// Depends on cdst_pkg and channel_dwell_share_tracker_assert.svh.
`include "channel_dwell_share_tracker_assert.svh"

module cdst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  cdst_pkg::dp_status_t status_i,
  output cdst_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_ACC_WR = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DEC_RD = 4'd4;
  localparam logic [3:0] S_DEC_WR = 4'd5;
  localparam logic [3:0] S_Q_MUL  = 4'd6;
  localparam logic [3:0] S_Q_DIV  = 4'd7;
  localparam logic [3:0] S_Q_OUT  = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        // The channel entry is read here whatever the item; branch on its kind.
        if (status_i.is_query) begin
          state_d = status_i.fallback ? S_Q_OUT : S_Q_MUL;
        end else begin
          state_d = status_i.in_range ? S_ACC_WR : S_CHECK;
        end
      end
      S_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.over_limit) begin
          cmd_o.win_decay = 1'b1;
          cmd_o.walk_clr  = 1'b1;
          state_d         = S_DEC_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DEC_RD: begin
        cmd_o.rd_walk = 1'b1;
        state_d       = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd_o.dec_wr = 1'b1;
        state_d      = status_i.walk_last ? S_IDLE : S_DEC_RD;
      end
      S_Q_MUL: begin
        cmd_o.mul_ld = 1'b1;
        state_d      = S_Q_DIV;
      end
      S_Q_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        cmd_o.out_fire = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `CDST_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `CDST_ASSERT_NEXT(a_div_then_out, cmd_o.div_step && status_i.div_last, state_q == S_Q_OUT)
  `CDST_ASSERT_NOW(a_idle_no_write, !busy_o, !(cmd_o.acc_wr || cmd_o.dec_wr))

endmodule

/* sv/cdst_dp.sv */
// Datapath of the channel dwell share tracker: item register, dwell RAM with
// valid bits, window counter, 7/8 decay, product and restoring divider, result.
// Depends on cdst_pkg, cdst_ram and channel_dwell_share_tracker_assert.svh.
`include "channel_dwell_share_tracker_assert.svh"

module cdst_dp #(
  parameter int unsigned CHANNEL_MAX = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdst_pkg::in_item_t                item_i,
  input  logic                              cfg_we_i,
  input  logic [cdst_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  cdst_pkg::dp_cmd_t                 cmd_i,
  output cdst_pkg::dp_status_t              status_o,
  output logic                              strobe_o,
  output cdst_pkg::result_t                 result_o
);

  localparam int unsigned DEPTH = CHANNEL_MAX + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_MAX);
  localparam logic [cdst_pkg::CHAN_W-1:0] MAX_CH = cdst_pkg::CHAN_W'(CHANNEL_MAX);
  localparam int unsigned DW = cdst_pkg::DWELL_W;
  localparam int unsigned WW = cdst_pkg::WINDOW_W;

  cdst_pkg::in_item_t item_q;
  logic [cdst_pkg::CFG_W-1:0] plan_q;
  logic [WW-1:0]        window_q;
  logic [DEPTH-1:0]     valid_q;
  logic                 rd_valid_q;
  logic [IDX_W-1:0]     walk_q;
  logic [cdst_pkg::PROD_W-1:0] quo_q;
  logic [WW-1:0]        rem_q;
  logic [cdst_pkg::CNT_W-1:0] cnt_q;
  logic                 strobe_q;
  logic [cdst_pkg::SHARE_W-1:0] share_q;
  logic [cdst_pkg::CHAN_W-1:0]  ch_q;

  logic [IDX_W-1:0] ch_idx, raddr, waddr;
  logic [DW-1:0]    rdata, dwell, acc_sum, dwell_dec, wdata;
  logic [DW+2:0]    dwell_x7;
  logic [WW+2:0]    win_x7;
  logic             we;
  logic             in_range;
  logic [WW+1:0]    trial;
  logic [cdst_pkg::SHARE_W-1:0] share_d;

  assign ch_idx   = item_q.channel[IDX_W-1:0];
  assign in_range = (item_q.channel <= MAX_CH);
  assign raddr    = cmd_i.rd_walk ? walk_q : ch_idx;

  // An entry never written since reset reads as zero.
  assign dwell = rd_valid_q ? rdata : '0;

  assign acc_sum   = dwell + item_q.duration_us;
  assign dwell_x7  = {dwell, 3'b000} - {3'b000, dwell};
  assign dwell_dec = dwell_x7[DW+2:3];
  assign win_x7    = {window_q, 3'b000} - {3'b000, window_q};

  assign we    = cmd_i.acc_wr || cmd_i.dec_wr;
  assign waddr = cmd_i.dec_wr ? walk_q : ch_idx;
  assign wdata = cmd_i.dec_wr ? dwell_dec : acc_sum;

  cdst_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_dwell_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q     <= '0;
      window_q   <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      walk_q     <= '0;
      cnt_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        plan_q <= cfg_wdata_i;
      end
      rd_valid_q <= valid_q[raddr];
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.acc_wr) begin
        window_q <= window_q + {1'b0, item_q.duration_us};
      end else if (cmd_i.win_decay) begin
        window_q <= win_x7[WW+2:3];
      end
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
      end else if (cmd_i.dec_wr) begin
        walk_q <= walk_q + IDX_W'(1);
      end
      if (cmd_i.mul_ld) begin
        cnt_q <= cdst_pkg::CNT_W'(cdst_pkg::DIV_W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - cdst_pkg::CNT_W'(1);
      end
      strobe_q <= cmd_i.out_fire;
    end
  end

  // Restoring division, one quotient bit per step; the dividend shifts out
  // of the top of quo_q while quotient bits enter at the bottom.
  assign trial = {1'b0, rem_q, quo_q[cdst_pkg::PROD_W-1]} - {2'b00, window_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_ld) begin
      quo_q <= cdst_pkg::PROD_W'(dwell) * cdst_pkg::PROD_W'(cdst_pkg::PERMIL);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[WW+1]) begin
        rem_q <= trial[WW-1:0];
        quo_q <= {quo_q[cdst_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[WW-2:0], quo_q[cdst_pkg::PROD_W-1]};
        quo_q <= {quo_q[cdst_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (status_o.fallback) begin
      share_d = cdst_pkg::fallback_share(plan_q);
    end else if (quo_q > cdst_pkg::PROD_W'(cdst_pkg::PERMIL)) begin
      share_d = cdst_pkg::PERMIL;
    end else begin
      share_d = quo_q[cdst_pkg::SHARE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_fire) begin
      share_q <= share_d;
      ch_q    <= item_q.channel;
    end
  end

  assign status_o.is_query   = (item_q.cmd == cdst_pkg::CMD_QUERY);
  assign status_o.in_range   = in_range;
  assign status_o.fallback   = !in_range || (window_q == '0);
  assign status_o.over_limit = (window_q > cdst_pkg::DECAY_LIMIT);
  assign status_o.walk_last  = (walk_q == LAST_IDX);
  assign status_o.div_last   = (cnt_q == cdst_pkg::CNT_W'(1));

  assign strobe_o                 = strobe_q;
  assign result_o.share_permil    = share_q;
  assign result_o.queried_channel = ch_q;

  `CDST_ASSERT_NOW(a_share_bound, strobe_q, share_q <= cdst_pkg::PERMIL)
  `CDST_ASSERT_NEXT(a_decay_shrinks, cmd_i.win_decay, window_q <= $past(window_q))
  `CDST_ASSERT_NEXT(a_div_loaded, cmd_i.mul_ld, cnt_q == cdst_pkg::CNT_W'(cdst_pkg::DIV_W))

endmodule

/* bench/cdst_share_checker.sv */
// Checker for the channel dwell share tracker: follows the dwell counters and the window
// from the accepted items, predicts every share result and compares it field by field.
// Depends on cdst_pkg for the item, result and constant definitions.
module cdst_share_checker #(
  parameter int unsigned CHANNEL_MAX = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  cdst_pkg::in_item_t          item_i,
  input  logic                        cfg_we_i,
  input  logic [cdst_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        res_strobe_i,
  input  cdst_pkg::result_t           result_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 shares_seen_o,
  output int unsigned                 shares_pending_o
);

  // Plan size assumed when the register holds zero.
  localparam logic [63:0] DEFAULT_PLAN = 64'd14;

  logic [cdst_pkg::DWELL_W-1:0]  dwell [0:CHANNEL_MAX];
  logic [cdst_pkg::WINDOW_W-1:0] window;
  logic [cdst_pkg::CFG_W-1:0]    plan_count;
  cdst_pkg::result_t             share_queue [$];

  function automatic logic [cdst_pkg::SHARE_W-1:0] predict_share(
    input logic [cdst_pkg::CHAN_W-1:0] ch
  );
    logic [63:0] wide;
    logic [63:0] divisor;
    if (ch > CHANNEL_MAX || window == '0) begin
      divisor = (plan_count == '0) ? DEFAULT_PLAN : 64'(plan_count);
      wide    = 64'(cdst_pkg::PERMIL) / divisor;
    end else begin
      wide = (64'(dwell[ch]) * 64'(cdst_pkg::PERMIL)) / 64'(window);
      if (wide > 64'(cdst_pkg::PERMIL)) wide = 64'(cdst_pkg::PERMIL);
    end
    return wide[cdst_pkg::SHARE_W-1:0];
  endfunction

  // Adds the duration when the channel exists, then scales everything by 7/8 once
  // the window has gone past ten seconds.
  function automatic void credit_channel(input logic [cdst_pkg::CHAN_W-1:0] ch,
                                         input logic [cdst_pkg::DWELL_W-1:0] us);
    if (ch <= CHANNEL_MAX) begin
      dwell[ch] = dwell[ch] + us;
      window    = window + cdst_pkg::WINDOW_W'(us);
    end
    if (window > cdst_pkg::DECAY_LIMIT) begin
      for (int c = 0; c <= CHANNEL_MAX; c++) begin
        dwell[c] = cdst_pkg::DWELL_W'((64'(dwell[c]) * 64'd7) / 64'd8);
      end
      window = cdst_pkg::WINDOW_W'((64'(window) * 64'd7) / 64'd8);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cdst_pkg::result_t want;
    if (!rst_ni) begin
      for (int c = 0; c <= CHANNEL_MAX; c++) begin
        dwell[c] = '0;
      end
      window        = '0;
      plan_count    = '0;
      share_queue.delete();
      fail_count_o  = 0;
      shares_seen_o = 0;
    end else begin
      if (res_strobe_i) begin
        if (share_queue.size() == 0) begin
          $display("%0t: unexpected share result: expected none, actual channel %0d, share %0d",
                   $time, result_i.queried_channel, result_i.share_permil);
          fail_count_o++;
        end else begin
          want = share_queue.pop_front();
          shares_seen_o++;
          if (result_i.share_permil !== want.share_permil) begin
            $display("%0t: share_permil mismatch: expected %0d, actual %0d", $time,
                     want.share_permil, result_i.share_permil);
            fail_count_o++;
          end
          if (result_i.queried_channel !== want.queried_channel) begin
            $display("%0t: queried_channel mismatch: expected %0d, actual %0d", $time,
                     want.queried_channel, result_i.queried_channel);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) plan_count = cfg_wdata_i;
      if (start_i && !busy_i) begin
        if (item_i.cmd == cdst_pkg::CMD_QUERY) begin
          want.share_permil    = predict_share(item_i.channel);
          want.queried_channel = item_i.channel;
          share_queue.push_back(want);
        end else begin
          credit_channel(item_i.channel, item_i.duration_us);
        end
      end
    end
    shares_pending_o = share_queue.size();
  end

endmodule

/* bench/tb_channel_dwell_share_tracker.sv */
// Testbench top for the channel dwell share tracker: clock, reset, stimulus and verdict.
// Depends on cdst_pkg, the tracker RTL and cdst_share_checker, which checks every share result.
module tb_channel_dwell_share_tracker;

  localparam int unsigned CHANNEL_MAX  = 14;
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned PHASES       = 5;
  // A query raises its result after the read, product, divider and output steps, and an
  // account keeps the block busy through any decay walk, so this covers any work in flight.
  localparam int unsigned SETTLE_CYCLES = 60;

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         start     = 1'b0;
  logic                         busy;
  cdst_pkg::in_item_t           item      = '0;
  logic                         cfg_we    = 1'b0;
  logic [cdst_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                         res_strobe;
  cdst_pkg::result_t            result;

  int unsigned fail_count;
  int unsigned shares_seen;
  int unsigned shares_pending;
  int unsigned items_sent = 0;
  int unsigned plans_used = 0;

  always #1 clk_i = ~clk_i;

  channel_dwell_share_tracker #(
    .CHANNEL_MAX (CHANNEL_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .res_strobe_o (res_strobe),
    .result_o     (result)
  );

  cdst_share_checker #(
    .CHANNEL_MAX (CHANNEL_MAX)
  ) share_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .res_strobe_i     (res_strobe),
    .result_i         (result),
    .fail_count_o     (fail_count),
    .shares_seen_o    (shares_seen),
    .shares_pending_o (shares_pending)
  );

  function automatic cdst_pkg::in_item_t make_item(
    input logic                           cmd,
    input logic [cdst_pkg::CHAN_W-1:0]    ch,
    input logic [cdst_pkg::DWELL_W-1:0]   us
  );
    cdst_pkg::in_item_t it;
    it.cmd         = cmd;
    it.channel     = ch;
    it.duration_us = us;
    return it;
  endfunction

  // Most items name a channel of the plan with a realistic dwell of tens to hundreds of
  // milliseconds, so that the window builds up and decays again and again. The rest are
  // out-of-range channels and extreme or fully random durations, which drive the
  // counters into wrap-around.
  function automatic cdst_pkg::in_item_t random_item();
    cdst_pkg::in_item_t it;
    int unsigned        sel;
    it.cmd = ($urandom_range(0, 99) < 40) ? cdst_pkg::CMD_QUERY : cdst_pkg::CMD_ACCOUNT;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      it.channel = cdst_pkg::CHAN_W'($urandom_range(0, CHANNEL_MAX));
    end else if (sel == 8) begin
      it.channel = cdst_pkg::CHAN_W'($urandom_range(CHANNEL_MAX + 1, 255));
    end else begin
      it.channel = $urandom_range(0, 1) ? 8'd255 : cdst_pkg::CHAN_W'(CHANNEL_MAX + 1);
    end
    sel = $urandom_range(0, 19);
    if (sel < 15)       it.duration_us = $urandom_range(20_000, 600_000);
    else if (sel < 17)  it.duration_us = $urandom_range(0, 1000);
    else if (sel == 17) it.duration_us = $urandom_range(0, 1) ? '1 : '0;
    else                it.duration_us = $urandom;
    return it;
  endfunction

  // Mostly short pauses between transfers, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  // Presents one item from a falling edge and holds it until a rising edge with busy low
  // completes the transfer. Start is left high, so a following item with no gap goes out
  // back to back.
  task automatic send_item(input cdst_pkg::in_item_t it);
    @(negedge clk_i);
    start <= 1'b1;
    item  <= it;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic pause(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // The plan register is only changed with the block idle: every share is back and any
  // trailing decay walk of an account item has had time to finish.
  task automatic write_plan(input logic [cdst_pkg::CFG_W-1:0] n);
    @(negedge clk_i);
    start <= 1'b0;
    while (shares_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    plans_used++;
  endtask

  // Directed opening with the plan register at its reset value. It covers the empty
  // window fallback, accounts to channels that do not exist, a zero duration, shares of
  // exactly all and nothing, the first decay past ten seconds and full-scale durations
  // that wrap the counters.
  task automatic run_directed();
    cdst_pkg::in_item_t seq [$];
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd0,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd255, '1));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd15,  '1));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd255, 32'd1234));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd14,  32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd0,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd0,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd3,   32'd5_000_000));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd3,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd4,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd14,  32'd4_000_000));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd3,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd14,  32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd7,   32'd2_000_000));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd7,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd15,  32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd9,   '1));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd10,  '1));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd9,   '1));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd10,  '1));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd9,   32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd10,  32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_ACCOUNT, 8'd200, 32'd0));
    seq.push_back(make_item(cdst_pkg::CMD_QUERY,   8'd9,   32'd0));
    foreach (seq[i]) begin
      pause(random_gap());
      send_item(seq[i]);
    end
  endtask

  initial begin
    logic [cdst_pkg::CFG_W-1:0] plans [PHASES];
    bit                         no_gaps;
    plans[0] = 4'd15;
    plans[1] = 4'd1;
    plans[2] = cdst_pkg::CFG_W'($urandom_range(2, 13));
    plans[3] = 4'd14;
    plans[4] = 4'd0;
    no_gaps  = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // Each phase opens with an out-of-range query so that the fallback share is seen
    // under each plan size written, then carries on with random traffic. The counters are not
    // cleared between phases, so the decay history runs through the whole test.
    for (int p = 0; p < PHASES; p++) begin
      write_plan(plans[p]);
      send_item(make_item(cdst_pkg::CMD_QUERY, 8'd255, 32'd0));
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (!no_gaps) pause(random_gap());
        send_item(random_item());
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (shares_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Summary: %0d items transferred, %0d shares compared, %0d plan sizes written.",
             items_sent, shares_seen, plans_used);
    $display("Covered: empty window, unknown channels, decay past ten seconds, counter wrap.");
    if (fail_count == 0 && shares_pending == 0) begin
      $display("PASS channel_dwell_share_tracker");
    end else begin
      $display("FAIL channel_dwell_share_tracker");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished by this delay.
  initial begin
    #2_000_000;
    $display("Timeout with %0d shares still outstanding.", shares_pending);
    $display("FAIL channel_dwell_share_tracker");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/cdst_pkg.sv
sv/cdst_ram.sv
sv/cdst_ctrl.sv
sv/cdst_dp.sv
sv/channel_dwell_share_tracker.sv
bench/cdst_share_checker.sv
bench/tb_channel_dwell_share_tracker.sv
